[hdl/mtxq_pkg.sv]
// Package for the mutex with wait queue: sizes, codes and types.
// No dependencies; used by mtxq_queue and mutex_grant_with_wait_queue.
package mtxq_pkg;

  localparam int unsigned QueueDepth = 128;
  localparam int unsigned IdBits     = 16;
  localparam int unsigned PtrBits    = $clog2(QueueDepth);
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);
  localparam int unsigned InDataW    = ((IdBits + 7) / 8) * 8;
  localparam int unsigned OutDataW   = ((2 * IdBits + 7) / 8) * 8;
  localparam int unsigned StatusBits = 2;

  typedef logic [IdBits-1:0] id_t;

  typedef enum logic {
    KIND_LOCK   = 1'b0,
    KIND_UNLOCK = 1'b1
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK      = 2'd0,
    ST_ALREADY = 2'd1,
    ST_DENIED  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GRANT,
    S_SECOND
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    id_t  data;
  } q_req_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [CntBits-1:0] count;
  } q_stat_t;

endpackage

[hdl/mtxq_queue.sv]
// Circular wait queue of requester ids held in a synchronous memory.
// Depends on mtxq_pkg; read data is registered on a pop and appears in the cycle after it.
module mtxq_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mtxq_pkg::q_req_t req_i,
  output mtxq_pkg::id_t    rdata_o,
  output mtxq_pkg::q_stat_t stat_o
);
  import mtxq_pkg::*;

  id_t                mem [QueueDepth];
  id_t                rdata_q;
  logic [PtrBits-1:0] head_q, head_d;
  logic [PtrBits-1:0] tail_q, tail_d;
  logic [CntBits-1:0] count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[tail_q] <= req_i.data;
    end
    if (req_i.pop) begin
      rdata_q <= mem[head_q];
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.push) begin
      tail_d = (tail_q == PtrBits'(QueueDepth - 1)) ? '0 : tail_q + PtrBits'(1);
    end
    if (req_i.pop) begin
      head_d = (head_q == PtrBits'(QueueDepth - 1)) ? '0 : head_q + PtrBits'(1);
    end
    if (req_i.push && !req_i.pop) begin
      count_d = count_q + CntBits'(1);
    end else if (req_i.pop && !req_i.push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign rdata_o      = rdata_q;
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntBits'(QueueDepth));

endmodule

[hdl/mutex_grant_with_wait_queue.sv]
// Top level of the mutex with a first-in first-out wait queue.
// Depends on mtxq_pkg and mtxq_queue.
//
//   port group  dir  tdata                          tuser       tlast
//   s_axis      in   requester_id                   kind        -
//   m_axis      out  dest_id [15:0], holder_id [31:16]  status  last
//
// A request that needs no queue read gives its reply, if it has one, in the cycle
// after it is accepted; a lock that is queued gives none. The next request can
// be accepted in the following cycle if m_axis is ready or no reply is pending.
// An unlock that hands the mutex to a waiter reads the queue memory (a registered
// read) and then sends two replies.
// Reset frees the mutex and empties the queue. A stalled m_axis holds back
// s_axis_tready; a new request waits until the reply register can take it.
module mutex_grant_with_wait_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mtxq_pkg::InDataW-1:0]        s_axis_tdata,  // requester_id
  input  logic                                s_axis_tuser,  // kind
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mtxq_pkg::OutDataW-1:0]       m_axis_tdata,  // dest_id, holder_id
  output logic [mtxq_pkg::StatusBits-1:0]     m_axis_tuser,  // status
  output logic                                m_axis_tlast   // last
);
  import mtxq_pkg::*;

  state_e  state_q, state_d;
  id_t     holder_q, holder_d;
  id_t     req_id_q, req_id_d;
  logic    out_valid_q, out_valid_d;
  id_t     out_dest_q, out_dest_d;
  id_t     out_holder_q, out_holder_d;
  status_e out_status_q, out_status_d;
  logic    out_last_q, out_last_d;
  logic    out_free;
  logic    accept;
  id_t     in_id;
  kind_e   in_kind;
  q_req_t  q_req;
  q_stat_t q_stat;
  id_t     q_rdata;

  mtxq_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (q_req),
    .rdata_o(q_rdata),
    .stat_o (q_stat)
  );

  assign in_id         = s_axis_tdata[IdBits-1:0];
  assign in_kind       = kind_e'(s_axis_tuser);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    holder_d     = holder_q;
    req_id_d     = req_id_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_dest_d   = out_dest_q;
    out_holder_d = out_holder_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    q_req        = '{push: 1'b0, pop: 1'b0, data: in_id};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_dest_d = in_id;
          out_last_d = 1'b1;
          if (in_kind == KIND_LOCK) begin
            if (holder_q == '0) begin
              holder_d     = in_id;
              out_valid_d  = 1'b1;
              out_status_d = ST_OK;
              out_holder_d = in_id;
            end else if (holder_q == in_id) begin
              out_valid_d  = 1'b1;
              out_status_d = ST_ALREADY;
              out_holder_d = holder_q;
            end else if (q_stat.full) begin
              out_valid_d  = 1'b1;
              out_status_d = ST_FULL;
              out_holder_d = holder_q;
            end else begin
              q_req.push = 1'b1;
            end
          end else begin
            if (holder_q == '0 || holder_q == in_id) begin
              if (q_stat.empty) begin
                holder_d     = '0;
                out_valid_d  = 1'b1;
                out_status_d = ST_OK;
                out_holder_d = '0;
              end else begin
                q_req.pop = 1'b1;
                req_id_d  = in_id;
                state_d   = S_GRANT;
              end
            end else begin
              out_valid_d  = 1'b1;
              out_status_d = ST_DENIED;
              out_holder_d = holder_q;
            end
          end
        end
      end
      S_GRANT: begin
        // The reply register was freed when the unlock was accepted.
        holder_d     = q_rdata;
        out_valid_d  = 1'b1;
        out_dest_d   = req_id_q;
        out_status_d = ST_OK;
        out_holder_d = q_rdata;
        out_last_d   = 1'b0;
        state_d      = S_SECOND;
      end
      S_SECOND: begin
        if (m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_dest_d   = holder_q;
          out_status_d = ST_OK;
          out_holder_d = holder_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      holder_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      holder_q    <= holder_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_id_q     <= req_id_d;
    out_dest_q   <= out_dest_d;
    out_holder_q <= out_holder_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_holder_q, out_dest_q});
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_req.pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_req.push |-> !q_stat.full)
    else $error("queue pushed while full");

  a_grant_first_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRANT) |=> (m_axis_tvalid && !m_axis_tlast && state_q == S_SECOND))
    else $error("first of two replies not presented after queue read");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == S_IDLE && !q_req.pop && !q_req.push) || accept)
    else $error("request port ready outside idle");

endmodule
